>>> rtl/core/tgd_pkg.sv
package tgd_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 8;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_SENSOR_PRESENT  = 3'd0,
      CSR_FLAT_LIMIT      = 3'd1,
      CSR_TRIGGER_LIMIT   = 3'd2,
      CSR_MOTION_DELTA    = 3'd3,
      CSR_SPORT_MSG_LIMIT = 3'd4
   } csr_index_type;

   localparam logic       RST_SENSOR_PRESENT  = 1'b1;
   localparam logic [7:0] RST_FLAT_LIMIT      = 8'd16;
   localparam logic [6:0] RST_TRIGGER_LIMIT   = 7'd48;
   localparam logic [7:0] RST_MOTION_DELTA    = 8'd2;
   localparam logic [7:0] RST_SPORT_MSG_LIMIT = 8'd90;

   typedef enum logic [2:0] {
      ORI_NONE    = 3'd0,
      ORI_FACE_UP = 3'd1,
      ORI_FACE_DN = 3'd2,
      ORI_SIDE_UP = 3'd3,
      ORI_SIDE_DN = 3'd4,
      ORI_RIGHT   = 3'd5,
      ORI_LEFT    = 3'd6
   } orient_type;

   // only the resting steps of the gesture are stored
   typedef enum logic [1:0] {
      STEP_IDLE = 2'd0,
      STEP_TILT = 2'd1,
      STEP_FLIP = 2'd2
   } step_type;

   typedef enum logic [2:0] {
      EV_NONE  = 3'd0,
      EV_TILT  = 3'd1,
      EV_FLIP  = 3'd2,
      EV_SHUT  = 3'd3,
      EV_SPORT = 3'd4
   } gesture_event_type;

   typedef struct packed {
      logic       sensor_present;
      logic [7:0] flat_limit;
      logic [6:0] trigger_limit;
      logic [7:0] motion_delta;
      logic [7:0] sport_msg_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [7:0] accel_x;
      logic signed [7:0] accel_y;
      logic signed [7:0] accel_z;
      logic              read_error;
      logic [7:0]        msg_count;
      logic              gps_on;
   } item_type;

   typedef struct packed {
      logic       active;
      logic       moved;
      orient_type orientation;
   } motion_type;

   typedef struct packed {
      logic       moved;
      orient_type orientation;
      logic       ack_blink;
      logic       shutdown_request;
      logic       sport_toggled;
      logic       sport_on;
      logic       gps_start;
   } result_type;

endpackage

>>> rtl/core/tilt_gesture_detector.sv
// Tilt and gesture detector. Each req transaction carries one accelerometer sample
// plus the read-error flag, the day's message count and the GPS-active flag, and
// yields exactly one rsp transaction. One sample is taken per clock while req_stall
// is low. An accepted sample is captured in the input register and its result is
// then held in the output register, where rsp_valid marks it until it is taken.
// Motion check, posture classification and the gesture step all resolve combinationally
// between those registers, which sets the one-per-clock rate. csr_ready is always
// high; write the registers only while no transaction is in flight.
module tilt_gesture_detector (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tgd_pkg::CsrIndexWidth-1:0]      csr_index,
   input  logic [tgd_pkg::CsrDataWidth-1:0]       csr_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [7:0]                      req_accel_x,
   input  logic signed [7:0]                      req_accel_y,
   input  logic signed [7:0]                      req_accel_z,
   input  logic                                   req_read_error,
   input  logic [7:0]                             req_msg_count,
   input  logic                                   req_gps_on,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_moved,
   output logic [2:0]                             rsp_orientation,
   output logic                                   rsp_ack_blink,
   output logic                                   rsp_shutdown_request,
   output logic                                   rsp_sport_toggled,
   output logic                                   rsp_sport_on,
   output logic                                   rsp_gps_start
);
   import tgd_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   result_type res_ff, res_in;
   logic       out_valid_ff, out_valid_in;
   logic       advance;
   motion_type mot;
   result_type res;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SENSOR_PRESENT:  cfg_in.sensor_present  = csr_data[0];
            CSR_FLAT_LIMIT:      cfg_in.flat_limit      = csr_data;
            CSR_TRIGGER_LIMIT:   cfg_in.trigger_limit   = csr_data[6:0];
            CSR_MOTION_DELTA:    cfg_in.motion_delta    = csr_data;
            CSR_SPORT_MSG_LIMIT: cfg_in.sport_msg_limit = csr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // input register; it moves on whenever the output register can take a result
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in = req_stall ? in_valid_ff : req_valid;
      item_in     = item_ff;
      if (req_valid && !req_stall) begin
         item_in.accel_x    = req_accel_x;
         item_in.accel_y    = req_accel_y;
         item_in.accel_z    = req_accel_z;
         item_in.read_error = req_read_error;
         item_in.msg_count  = req_msg_count;
         item_in.gps_on     = req_gps_on;
      end
   end

   tgd_motion u_motion (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .item    (item_ff),
      .process (advance),
      .mot     (mot)
   );

   tgd_gesture u_gesture (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .item    (item_ff),
      .mot     (mot),
      .process (advance),
      .res     (res)
   );

   // output register
   always_comb begin
      res_in       = advance ? res : res_ff;
      out_valid_in = advance || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensor_present  <= RST_SENSOR_PRESENT;
         cfg_ff.flat_limit      <= RST_FLAT_LIMIT;
         cfg_ff.trigger_limit   <= RST_TRIGGER_LIMIT;
         cfg_ff.motion_delta    <= RST_MOTION_DELTA;
         cfg_ff.sport_msg_limit <= RST_SPORT_MSG_LIMIT;
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      res_ff  <= res_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_moved            = res_ff.moved;
   assign rsp_orientation      = res_ff.orientation;
   assign rsp_ack_blink        = res_ff.ack_blink;
   assign rsp_shutdown_request = res_ff.shutdown_request;
   assign rsp_sport_toggled    = res_ff.sport_toggled;
   assign rsp_sport_on         = res_ff.sport_on;
   assign rsp_gps_start        = res_ff.gps_start;

`ifndef SYNTHESIS
   a_gesture_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_shutdown_request && rsp_sport_toggled))
      else $error("shutdown and sport toggle in one result");

   a_gps_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gps_start |-> rsp_sport_toggled && rsp_sport_on && rsp_moved)
      else $error("gps start without sport enable");

   a_gesture_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_shutdown_request || rsp_sport_toggled) |-> rsp_ack_blink)
      else $error("gesture completed without acknowledge");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled while the pipeline can move");
`endif

endmodule

>>> rtl/core/tgd_motion.sv
module tgd_motion (
   input  logic              clock,
   input  logic              reset,
   input  tgd_pkg::cfg_type  cfg,
   input  tgd_pkg::item_type item,
   input  logic              process,
   output tgd_pkg::motion_type mot
);
   import tgd_pkg::*;

   logic [7:0] prev_x_ff, prev_y_ff, prev_z_ff;
   logic [7:0] prev_x_in, prev_y_in, prev_z_in;
   logic [7:0] dx, dy, dz;
   logic       active;
   logic       over;
   logic       fx, fy, fz;
   logic       px, py, pz, nx, ny, nz;
   logic signed [8:0] t9, x9, y9, z9;
   orient_type ori;

   function automatic logic [7:0] mag8(input logic [7:0] v);
      mag8 = v[7] ? (~v + 8'd1) : v;
   endfunction

   always_comb begin
      active = cfg.sensor_present && !item.read_error;
      dx = item.accel_x - prev_x_ff;
      dy = item.accel_y - prev_y_ff;
      dz = item.accel_z - prev_z_ff;
      over = (mag8(dx) > cfg.motion_delta) || (mag8(dy) > cfg.motion_delta) ||
             (mag8(dz) > cfg.motion_delta);
   end

   // posture classification on the new sample
   always_comb begin
      t9 = $signed({2'b00, cfg.trigger_limit});
      x9 = $signed({item.accel_x[7], item.accel_x});
      y9 = $signed({item.accel_y[7], item.accel_y});
      z9 = $signed({item.accel_z[7], item.accel_z});
      fx = mag8(item.accel_x) < cfg.flat_limit;
      fy = mag8(item.accel_y) < cfg.flat_limit;
      fz = mag8(item.accel_z) < cfg.flat_limit;
      px = x9 > t9;
      py = y9 > t9;
      pz = z9 > t9;
      nx = x9 < -t9;
      ny = y9 < -t9;
      nz = z9 < -t9;
      priority if (fx && fy && pz) begin
         ori = ORI_FACE_UP;
      end else if (fx && fy && nz) begin
         ori = ORI_FACE_DN;
      end else if (fx && ny && fz) begin
         ori = ORI_SIDE_UP;
      end else if (fx && py && fz) begin
         ori = ORI_SIDE_DN;
      end else if (px && fy && fz) begin
         ori = ORI_RIGHT;
      end else if (nx && fy && fz) begin
         ori = ORI_LEFT;
      end else begin
         ori = ORI_NONE;
      end
   end

   always_comb begin
      mot.active      = active;
      mot.moved       = !active || over;
      mot.orientation = ori;
   end

   always_comb begin
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      prev_z_in = prev_z_ff;
      if (process && active) begin
         prev_x_in = item.accel_x;
         prev_y_in = item.accel_y;
         prev_z_in = item.accel_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         prev_z_ff <= '0;
      end else begin
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         prev_z_ff <= prev_z_in;
      end
   end

endmodule

>>> rtl/core/tgd_gesture.sv
module tgd_gesture (
   input  logic                clock,
   input  logic                reset,
   input  tgd_pkg::cfg_type    cfg,
   input  tgd_pkg::item_type   item,
   input  tgd_pkg::motion_type mot,
   input  logic                process,
   output tgd_pkg::result_type res
);
   import tgd_pkg::*;

   step_type          step_ff, step_in;
   orient_type        last_ff, last_in;
   logic              sport_ff, sport_in;
   gesture_event_type ev;
   logic              upd;
   logic              toggle;

   assign upd = process && mot.active && mot.moved;

   // transition decode; an unclassified posture matches nothing and falls to idle
   always_comb begin
      unique case (step_ff)
         STEP_IDLE: begin
            if (last_ff == ORI_FACE_UP && mot.orientation == ORI_SIDE_UP) begin
               ev = EV_TILT;
            end else begin
               ev = EV_NONE;
            end
         end
         STEP_TILT: begin
            if (last_ff == ORI_SIDE_UP && mot.orientation == ORI_SIDE_DN) begin
               ev = EV_FLIP;
            end else begin
               ev = EV_NONE;
            end
         end
         STEP_FLIP: begin
            if (last_ff == ORI_SIDE_DN && mot.orientation == ORI_SIDE_UP) begin
               ev = EV_SHUT;
            end else if (last_ff == ORI_SIDE_DN && mot.orientation == ORI_FACE_UP) begin
               ev = EV_SPORT;
            end else begin
               ev = EV_NONE;
            end
         end
         default: begin
            ev = EV_NONE;
         end
      endcase
   end

   // next state
   always_comb begin
      step_in = step_ff;
      if (upd) begin
         unique case (ev)
            EV_TILT: step_in = STEP_TILT;
            EV_FLIP: step_in = STEP_FLIP;
            default: step_in = STEP_IDLE;
         endcase
      end
   end

   // outputs and the other state
   always_comb begin
      toggle   = upd && (ev == EV_SPORT) && (item.msg_count < cfg.sport_msg_limit);
      sport_in = sport_ff ^ toggle;
      last_in  = upd ? mot.orientation : last_ff;
      res.moved            = mot.moved;
      res.orientation      = last_in;
      res.ack_blink        = upd && (ev != EV_NONE);
      res.shutdown_request = upd && (ev == EV_SHUT);
      res.sport_toggled    = toggle;
      res.sport_on         = sport_in;
      res.gps_start        = toggle && sport_in && !item.gps_on;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_IDLE;
         last_ff  <= ORI_NONE;
         sport_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         last_ff  <= last_in;
         sport_ff <= sport_in;
      end
   end

endmodule

>>> sim/tilt_gesture_detector_tb.sv
module tilt_gesture_detector_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tgd_pkg::*;

   typedef struct packed {
      logic signed [7:0] x;
      logic signed [7:0] y;
      logic signed [7:0] z;
      logic              err;
      logic [7:0]        msg;
      logic              gps;
      logic              typed;
      result_type        res;
   } dir_row_type;

   localparam result_type NO_RES        = '0;
   localparam result_type STILL_NONE    = '{1'b0, ORI_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
   localparam result_type MOVED_NONE    = '{1'b1, ORI_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
   localparam result_type MOVED_FACE_UP = '{1'b1, ORI_FACE_UP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

   // x, y, z, read error, msg count, gps, typed, expected
   localparam dir_row_type DIRECTED_ROWS [25] = '{
      '{   0,    0,    0, 1'b0,   0, 1'b0, 1'b1, STILL_NONE},
      '{   0,    0,    2, 1'b0,   0, 1'b0, 1'b1, STILL_NONE},
      '{ 127,    0,    0, 1'b1,   0, 1'b0, 1'b1, MOVED_NONE},
      '{   0,    0,   64, 1'b0,   0, 1'b0, 1'b1, MOVED_FACE_UP},
      '{   0,  -64,    0, 1'b0,   0, 1'b0, 1'b0, NO_RES},
      '{   0,   64,    0, 1'b0,   0, 1'b0, 1'b0, NO_RES},
      '{   0,    0,   64, 1'b0,  10, 1'b0, 1'b0, NO_RES},
      '{   0,  -64,    0, 1'b0,   0, 1'b0, 1'b0, NO_RES},
      '{   0,   64,    0, 1'b0,   0, 1'b0, 1'b0, NO_RES},
      '{   0,  -64,    0, 1'b0,   0, 1'b0, 1'b0, NO_RES},
      '{   0,    0,   64, 1'b0,   0, 1'b0, 1'b0, NO_RES},
      '{   0,  -64,    0, 1'b0,   0, 1'b0, 1'b0, NO_RES},
      '{   0,   64,    0, 1'b0,   0, 1'b0, 1'b0, NO_RES},
      '{   0,    0,   64, 1'b0, 200, 1'b0, 1'b0, NO_RES},
      '{   0,  -64,    0, 1'b0,   0, 1'b0, 1'b0, NO_RES},
      '{   0,   64,    0, 1'b0,   0, 1'b0, 1'b0, NO_RES},
      '{   0,    0,   64, 1'b0,   0, 1'b1, 1'b0, NO_RES},
      '{   0,  -64,    0, 1'b0,   0, 1'b0, 1'b0, NO_RES},
      '{-128, -128, -128, 1'b0,   0, 1'b0, 1'b1, MOVED_NONE},
      '{ 127,  127,  127, 1'b0,   0, 1'b0, 1'b1, STILL_NONE},
      '{   0,   64,    0, 1'b0,   0, 1'b0, 1'b0, NO_RES},
      '{   0,    0,  -64, 1'b0,   0, 1'b0, 1'b0, NO_RES},
      '{  64,    0,    0, 1'b0,   0, 1'b0, 1'b0, NO_RES},
      '{ -64,    0,    0, 1'b0,   0, 1'b0, 1'b0, NO_RES},
      '{ -64,    0,    0, 1'b0, 255, 1'b1, 1'b0, NO_RES}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = CSR_SENSOR_PRESENT;
   logic [CsrDataWidth-1:0]  csr_data  = '0;

   logic              req_valid      = 1'b0;
   logic              req_stall;
   logic signed [7:0] req_accel_x    = '0;
   logic signed [7:0] req_accel_y    = '0;
   logic signed [7:0] req_accel_z    = '0;
   logic              req_read_error = 1'b0;
   logic [7:0]        req_msg_count  = '0;
   logic              req_gps_on     = 1'b0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_moved;
   logic [2:0] rsp_orientation;
   logic       rsp_ack_blink;
   logic       rsp_shutdown_request;
   logic       rsp_sport_toggled;
   logic       rsp_sport_on;
   logic       rsp_gps_start;

   // predictor state and its copy of the registers
   cfg_type    tilt_cfg = '{RST_SENSOR_PRESENT, RST_FLAT_LIMIT, RST_TRIGGER_LIMIT,
                            RST_MOTION_DELTA, RST_SPORT_MSG_LIMIT};
   logic [7:0] held_x = '0;
   logic [7:0] held_y = '0;
   logic [7:0] held_z = '0;
   orient_type held_pose = ORI_NONE;
   step_type   gesture_phase = STEP_IDLE;
   logic       sport_q = 1'b0;

   result_type pending_tilt_results [$];
   item_type   last_sample = '0;

   int send_idle_pct   = 0;
   int rsp_stall_pct   = 0;
   int hold_request    = 0;
   int mismatch_count  = 0;
   int samples_sent    = 0;
   int results_checked = 0;
   int settings_applied = 0;
   int acks_seen       = 0;
   int shutdowns_seen  = 0;
   int toggles_seen    = 0;
   int gps_starts_seen = 0;

   tilt_gesture_detector u_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_accel_x          (req_accel_x),
      .req_accel_y          (req_accel_y),
      .req_accel_z          (req_accel_z),
      .req_read_error       (req_read_error),
      .req_msg_count        (req_msg_count),
      .req_gps_on           (req_gps_on),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_moved            (rsp_moved),
      .rsp_orientation      (rsp_orientation),
      .rsp_ack_blink        (rsp_ack_blink),
      .rsp_shutdown_request (rsp_shutdown_request),
      .rsp_sport_toggled    (rsp_sport_toggled),
      .rsp_sport_on         (rsp_sport_on),
      .rsp_gps_start        (rsp_gps_start)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int axis_mag(input logic signed [7:0] v);
      return (v < 0) ? -int'(v) : int'(v);
   endfunction

   function automatic orient_type classify_pose(input logic signed [7:0] x,
                                                input logic signed [7:0] y,
                                                input logic signed [7:0] z);
      int t;
      int fl;
      bit fx;
      bit fy;
      bit fz;
      t  = int'(tilt_cfg.trigger_limit);
      fl = int'(tilt_cfg.flat_limit);
      fx = axis_mag(x) < fl;
      fy = axis_mag(y) < fl;
      fz = axis_mag(z) < fl;
      if (fx && fy && int'(z) > t) return ORI_FACE_UP;
      if (fx && fy && int'(z) < -t) return ORI_FACE_DN;
      if (fx && int'(y) < -t && fz) return ORI_SIDE_UP;
      if (fx && int'(y) > t && fz) return ORI_SIDE_DN;
      if (int'(x) > t && fy && fz) return ORI_RIGHT;
      if (int'(x) < -t && fy && fz) return ORI_LEFT;
      return ORI_NONE;
   endfunction

   // axis change seen through 8-bit wraparound, 0..128
   function automatic bit axis_moved(input logic [7:0] now_v, input logic [7:0] old_v);
      logic signed [7:0] d;
      d = now_v - old_v;
      return axis_mag(d) > int'(tilt_cfg.motion_delta);
   endfunction

   function automatic result_type predict_tilt_result(input item_type it);
      result_type        r;
      orient_type        pose;
      step_type          st;
      gesture_event_type ev;
      r = '0;
      r.moved = 1'b1;
      if (tilt_cfg.sensor_present && !it.read_error) begin
         r.moved = axis_moved(it.accel_x, held_x) || axis_moved(it.accel_y, held_y) ||
                   axis_moved(it.accel_z, held_z);
         held_x = it.accel_x;
         held_y = it.accel_y;
         held_z = it.accel_z;
         if (r.moved) begin
            pose = classify_pose(it.accel_x, it.accel_y, it.accel_z);
            st   = (pose == ORI_NONE) ? STEP_IDLE : gesture_phase;
            ev   = EV_NONE;
            if (st == STEP_IDLE && held_pose == ORI_FACE_UP && pose == ORI_SIDE_UP)
               ev = EV_TILT;
            else if (st == STEP_TILT && held_pose == ORI_SIDE_UP && pose == ORI_SIDE_DN)
               ev = EV_FLIP;
            else if (st == STEP_FLIP && held_pose == ORI_SIDE_DN && pose == ORI_SIDE_UP)
               ev = EV_SHUT;
            else if (st == STEP_FLIP && held_pose == ORI_SIDE_DN && pose == ORI_FACE_UP)
               ev = EV_SPORT;
            r.ack_blink = (ev != EV_NONE);
            held_pose = pose;
            gesture_phase = STEP_IDLE;
            case (ev)
               EV_TILT: gesture_phase = STEP_TILT;
               EV_FLIP: gesture_phase = STEP_FLIP;
               EV_SHUT: r.shutdown_request = 1'b1;
               EV_SPORT: begin
                  // a refused toggle still acks the gesture
                  if (it.msg_count < tilt_cfg.sport_msg_limit) begin
                     sport_q = !sport_q;
                     r.sport_toggled = 1'b1;
                     r.gps_start = sport_q && !it.gps_on;
                  end
               end
               default: ;
            endcase
         end
      end
      r.orientation = held_pose;
      r.sport_on    = sport_q;
      return r;
   endfunction

   function automatic logic [7:0] flat_axis();
      int fl;
      fl = int'(tilt_cfg.flat_limit);
      if (fl == 0) return 8'($urandom);
      return 8'(int'($urandom_range(2 * fl - 2)) - (fl - 1));
   endfunction

   function automatic logic [7:0] gravity_axis(input bit negative);
      int t;
      t = int'(tilt_cfg.trigger_limit);
      if (negative) return 8'(-int'($urandom_range(128, t + 1)));
      if (t < 127) return 8'($urandom_range(127, t + 1));
      return 8'($urandom);
   endfunction

   function automatic item_type pose_sample(input orient_type o);
      item_type it;
      it.accel_x = flat_axis();
      it.accel_y = flat_axis();
      it.accel_z = flat_axis();
      case (o)
         ORI_FACE_UP: it.accel_z = gravity_axis(1'b0);
         ORI_FACE_DN: it.accel_z = gravity_axis(1'b1);
         ORI_SIDE_UP: it.accel_y = gravity_axis(1'b1);
         ORI_SIDE_DN: it.accel_y = gravity_axis(1'b0);
         ORI_RIGHT:   it.accel_x = gravity_axis(1'b0);
         ORI_LEFT:    it.accel_x = gravity_axis(1'b1);
         default: begin
            it.accel_x = 8'($urandom);
            it.accel_y = 8'($urandom);
            it.accel_z = 8'($urandom);
         end
      endcase
      it.read_error = ($urandom_range(15) == 0);
      // half the counts sit within one of the sport limit
      it.msg_count = $urandom_range(1) ? 8'($urandom_range(255)) :
                     tilt_cfg.sport_msg_limit + 8'($urandom_range(2)) - 8'd1;
      it.gps_on = 1'($urandom_range(1));
      return it;
   endfunction

   function automatic logic [7:0] jitter_axis(input logic [7:0] v);
      return v + 8'($urandom_range(6)) - 8'd3;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 50) $display("ERROR @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                   results_checked, name, got, want));
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_sample(input item_type it, input bit typed, input result_type want);
      result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_accel_x    = it.accel_x;
      req_accel_y    = it.accel_y;
      req_accel_z    = it.accel_z;
      req_read_error = it.read_error;
      req_msg_count  = it.msg_count;
      req_gps_on     = it.gps_on;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      r = predict_tilt_result(it);
      pending_tilt_results.push_back(typed ? want : r);
      last_sample = it;
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending_tilt_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [7:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SENSOR_PRESENT:  tilt_cfg.sensor_present  = val[0];
         CSR_FLAT_LIMIT:      tilt_cfg.flat_limit      = val;
         CSR_TRIGGER_LIMIT:   tilt_cfg.trigger_limit   = val[6:0];
         CSR_MOTION_DELTA:    tilt_cfg.motion_delta    = val;
         CSR_SPORT_MSG_LIMIT: tilt_cfg.sport_msg_limit = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_config(input logic sp, input logic [7:0] fl, input logic [6:0] tr,
                             input logic [7:0] md, input logic [7:0] lim);
      write_csr(CSR_SENSOR_PRESENT, {7'd0, sp});
      write_csr(CSR_FLAT_LIMIT, fl);
      write_csr(CSR_TRIGGER_LIMIT, {1'b0, tr});
      write_csr(CSR_MOTION_DELTA, md);
      write_csr(CSR_SPORT_MSG_LIMIT, lim);
      csr_valid = 1'b0;
      settings_applied++;
   endtask

   // mostly complete gestures with random content, plus postures, jitter and noise
   task automatic run_random(input int count);
      int         sent;
      int         roll;
      item_type   it;
      orient_type gesture [4];
      sent = 0;
      while (sent < count) begin
         roll = $urandom_range(99);
         if (roll < 50) begin
            gesture = '{ORI_FACE_UP, ORI_SIDE_UP, ORI_SIDE_DN,
                        $urandom_range(1) ? ORI_SIDE_UP : ORI_FACE_UP};
            foreach (gesture[i]) begin
               send_sample(pose_sample(gesture[i]), 1'b0, NO_RES);
               sent++;
            end
         end else if (roll < 72) begin
            send_sample(pose_sample(orient_type'($urandom_range(6))), 1'b0, NO_RES);
            sent++;
         end else if (roll < 90) begin
            it = pose_sample(ORI_NONE);
            it.accel_x = jitter_axis(last_sample.accel_x);
            it.accel_y = jitter_axis(last_sample.accel_y);
            it.accel_z = jitter_axis(last_sample.accel_z);
            send_sample(it, 1'b0, NO_RES);
            sent++;
         end else begin
            send_sample(pose_sample(ORI_NONE), 1'b0, NO_RES);
            sent++;
         end
      end
   endtask

   task automatic run_phase(input logic sp, input logic [7:0] fl, input logic [6:0] tr,
                            input logic [7:0] md, input logic [7:0] lim,
                            input int send_pct, input int stall_pct,
                            input int count, input int hold);
      wait_idle();
      set_config(sp, fl, tr, md, lim);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      hold_request  = hold;
      run_random(count);
   endtask

   // receiver pacing; a hold request keeps stall up for a long stretch
   initial begin : rsp_pacing
      int n;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            n = hold_request;
            hold_request = 0;
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall = ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_tilt_results.size() == 0) begin
            report_mismatch("result transaction with no sample pending");
         end else begin
            want = pending_tilt_results.pop_front();
            check_field("moved", 8'(rsp_moved), 8'(want.moved));
            check_field("orientation", 8'(rsp_orientation), 8'(want.orientation));
            check_field("ack_blink", 8'(rsp_ack_blink), 8'(want.ack_blink));
            check_field("shutdown_request", 8'(rsp_shutdown_request),
                        8'(want.shutdown_request));
            check_field("sport_toggled", 8'(rsp_sport_toggled), 8'(want.sport_toggled));
            check_field("sport_on", 8'(rsp_sport_on), 8'(want.sport_on));
            check_field("gps_start", 8'(rsp_gps_start), 8'(want.gps_start));
            acks_seen       += int'(want.ack_blink);
            shutdowns_seen  += int'(want.shutdown_request);
            toggles_seen    += int'(want.sport_toggled);
            gps_starts_seen += int'(want.gps_start);
            results_checked++;
         end
      end
   end

   initial begin : stimulus
      item_type it;
      int       send_modes [3];
      int       stall_modes [3];
      send_modes  = '{83, 0, 24};
      stall_modes = '{0, 83, 24};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         it.accel_x    = DIRECTED_ROWS[i].x;
         it.accel_y    = DIRECTED_ROWS[i].y;
         it.accel_z    = DIRECTED_ROWS[i].z;
         it.read_error = DIRECTED_ROWS[i].err;
         it.msg_count  = DIRECTED_ROWS[i].msg;
         it.gps_on     = DIRECTED_ROWS[i].gps;
         send_sample(it, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
      end

      run_phase(1'b1, 8'd16, 7'd48, 8'd2, 8'd90, 0, 0, 140, 80);
      run_phase(1'b0, 8'd16, 7'd48, 8'd2, 8'd90, 83, 0, 60, 0);
      run_phase(1'b1, 8'd128, 7'd0, 8'd0, 8'd255, 0, 83, 120, 0);
      run_phase(1'b1, 8'd0, 7'd127, 8'd255, 8'd0, 24, 24, 70, 0);
      run_phase(1'b1, 8'd40, 7'd20, 8'd5, 8'd128, 0, 0, 150, 60);
      for (int k = 0; k < 3; k++)
         run_phase(1'b1, 8'($urandom_range(128)), 7'($urandom_range(127)),
                   8'($urandom_range(8)), 8'($urandom_range(255)),
                   send_modes[k], stall_modes[k], 130, 0);
      wait_idle();

      $display("Checked %0d results from %0d samples over %0d register settings.",
               results_checked, samples_sent, settings_applied);
      $display("Gesture acks %0d, shutdowns %0d, sport toggles %0d, GPS starts %0d.",
               acks_seen, shutdowns_seen, toggles_seen, gps_starts_seen);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
